// File: hw/rtl/tvfc_pkg.sv
package tvfc_pkg;

    localparam int COORD_W = 32;
    localparam int NCOORD = 6;
    localparam int PAIR_W = COORD_W * NCOORD;
    localparam int ALPHA_W = 25;
    localparam int SPEED_W = 16;
    localparam int DT_W = 16;
    localparam int CLOCK_W = 17;
    localparam int FRAME_W = 8;
    localparam int SEG_W = 6;

    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 216;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_ACROSS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_DOWN = 2'd3;
    localparam int CFG_DATA_W = 16;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_INIT = 1'b1;

    localparam logic [ALPHA_W-1:0] ONE_Q24 = 25'h100_0000;
    localparam logic [CLOCK_W-1:0] CLOCK_MAX = 17'h1FFFF;

    // near_x, near_y, near_z, far_x, far_y, far_z from element 0 up
    typedef logic [NCOORD-1:0][COORD_W-1:0] pair_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] idx;
    } tag_t;

endpackage

// File: hw/rtl/tvfc_follow_unit.sv
module tvfc_follow_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tvfc_pkg::tag_t                     in_tag,
    input  logic [tvfc_pkg::COORD_W-1:0]       p,
    input  logic [tvfc_pkg::COORD_W-1:0]       d,
    input  logic [tvfc_pkg::ALPHA_W-1:0]       alpha,
    output tvfc_pkg::tag_t                     out_tag,
    output logic [tvfc_pkg::COORD_W-1:0]       result
);

    localparam int DIFF_W = tvfc_pkg::COORD_W + 1;
    localparam int PROD_W = DIFF_W + tvfc_pkg::ALPHA_W + 1;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< 23;

    tvfc_pkg::tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [tvfc_pkg::COORD_W-1:0] p1_reg, p2_reg, sum_reg;

    logic signed [DIFF_W-1:0] diff_next;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] rounded;
    logic [tvfc_pkg::COORD_W-1:0] sum_next;

    always_comb begin
        diff_next = $signed({d[tvfc_pkg::COORD_W-1], d}) - $signed({p[tvfc_pkg::COORD_W-1], p});
        prod_next = diff_reg * $signed({1'b0, alpha});
        // round to nearest, ties up, then floor shift by 24
        rounded = prod_reg + HALF;
        sum_next = p2_reg + rounded[tvfc_pkg::COORD_W+23:24];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end else begin
            s1_tag_reg <= in_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
        diff_reg <= diff_next;
        p1_reg <= p;
        prod_reg <= prod_next;
        p2_reg <= p1_reg;
        sum_reg <= sum_next;
    end

    assign out_tag = s3_tag_reg;
    assign result = sum_reg;

endmodule

// File: hw/rtl/trail_vertex_follow_chain.sv
// Trail follow chain: keeps SEGMENTS+1 vertex pairs and, on an update tick
// (tuser kind 0), pins pair 0 to the anchors, pulls each later pair toward the
// one before it by alpha = follow_speed*time_step (saturated at 1.0), advances
// the sprite frame and emits every pair in order, tlast on the final one. One
// three-stage multiply/round unit handles all coordinates, one per cycle:
// pair 0 is emitted after the frame update, and each later pair goes through
// a memory read, the issue of its six coordinates, a unit drain and its emit.
// An init item (kind 1) writes the anchors into every pair and emits nothing.
// s_tready is high only between items.
module trail_vertex_follow_chain #(
    parameter int SEGMENTS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // time_step[15:0], head_x, head_y, head_z, tail_x, tail_y, tail_z (32 each)
    input  logic [tvfc_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind[0]
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // segment[5:0], near_x, near_y, near_z, far_x, far_y, far_z (32 each),
    // frame_col[7:0], frame_row[7:0], two zero bits
    output logic [tvfc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [tvfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tvfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PAIRS = SEGMENTS + 1;
    localparam int IDX_W = $clog2(PAIRS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAIRS - 1);
    localparam logic [2:0] LAST_COORD = 3'(tvfc_pkg::NCOORD - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_FRAME = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_ISSUE = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [2:0] coord_reg;

    logic [tvfc_pkg::SPEED_W-1:0] follow_speed_reg;
    logic [tvfc_pkg::DT_W-1:0] frame_interval_reg;
    logic [tvfc_pkg::FRAME_W-1:0] frames_across_reg, frames_down_reg;

    logic [tvfc_pkg::CLOCK_W-1:0] frame_clock_reg;
    logic [tvfc_pkg::FRAME_W-1:0] frame_column_reg, frame_line_reg;

    logic [tvfc_pkg::DT_W-1:0] dt_reg;
    logic [tvfc_pkg::ALPHA_W-1:0] alpha_reg;
    tvfc_pkg::pair_t pair_reg, prev_reg, rd_data_reg;
    logic rd_valid_reg;

    tvfc_pkg::pair_t mem [PAIRS];
    logic [PAIRS-1:0] valid_reg;

    logic [tvfc_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic m_tlast_reg, m_tvalid_reg;

    logic accept, out_free, emit_fire, wr_en;
    logic [31:0] alpha_prod;
    logic [tvfc_pkg::ALPHA_W-1:0] alpha_next;
    tvfc_pkg::pair_t anchors;

    tvfc_pkg::tag_t issue_tag, res_tag;
    logic [tvfc_pkg::COORD_W-1:0] issue_p, issue_d, res_value;

    // frame advance
    logic [tvfc_pkg::CLOCK_W:0] clk_sum, clk_left;
    logic [tvfc_pkg::FRAME_W-1:0] across, down, col_inc, row_inc;
    logic [tvfc_pkg::FRAME_W-1:0] column_next, line_next;
    logic [tvfc_pkg::CLOCK_W-1:0] clock_next;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;
    assign wr_en = (state_reg == S_INIT) || emit_fire;
    assign anchors = tvfc_pkg::pair_t'(s_tdata[tvfc_pkg::S_TDATA_W-1:tvfc_pkg::DT_W]);

    always_comb begin
        alpha_prod = 32'(follow_speed_reg) * 32'(s_tdata[tvfc_pkg::DT_W-1:0]);
        alpha_next = (alpha_prod > 32'(tvfc_pkg::ONE_Q24))
            ? tvfc_pkg::ONE_Q24 : alpha_prod[tvfc_pkg::ALPHA_W-1:0];
    end

    always_comb begin
        across = (frames_across_reg == '0) ? 8'd1 : frames_across_reg;
        down = (frames_down_reg == '0) ? 8'd1 : frames_down_reg;
        clk_sum = {1'b0, frame_clock_reg} + 18'(dt_reg);
        clk_left = clk_sum;
        column_next = frame_column_reg;
        line_next = frame_line_reg;
        col_inc = frame_column_reg + 8'd1;
        row_inc = frame_line_reg + 8'd1;
        if (clk_sum >= 18'(frame_interval_reg)) begin
            clk_left = clk_sum - 18'(frame_interval_reg);
            column_next = col_inc;
            if (col_inc >= across) begin
                column_next = '0;
                line_next = (row_inc >= down) ? 8'd0 : row_inc;
            end
        end
        clock_next = (clk_left > 18'(tvfc_pkg::CLOCK_MAX))
            ? tvfc_pkg::CLOCK_MAX : clk_left[tvfc_pkg::CLOCK_W-1:0];
    end

    always_comb begin
        issue_tag.valid = (state_reg == S_ISSUE);
        issue_tag.idx = coord_reg;
        issue_p = rd_valid_reg ? rd_data_reg[coord_reg] : '0;
        issue_d = prev_reg[coord_reg];
    end

    tvfc_follow_unit u_follow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (issue_tag),
        .p       (issue_p),
        .d       (issue_d),
        .alpha   (alpha_reg),
        .out_tag (res_tag),
        .result  (res_value)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser[0] == tvfc_pkg::KIND_INIT) ? S_INIT : S_FRAME;
                end
            end
            S_INIT: begin
                if (cnt_reg == LAST_IDX) state_next = S_IDLE;
            end
            S_FRAME: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) state_next = (cnt_reg == LAST_IDX) ? S_IDLE : S_READ;
            end
            S_READ: state_next = S_ISSUE;
            S_ISSUE: begin
                if (coord_reg == LAST_COORD) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (res_tag.valid && res_tag.idx == LAST_COORD) state_next = S_EMIT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            coord_reg <= '0;
            follow_speed_reg <= 16'd2560;
            frame_interval_reg <= 16'd6554;
            frames_across_reg <= 8'd1;
            frames_down_reg <= 8'd1;
            frame_clock_reg <= '0;
            frame_column_reg <= '0;
            frame_line_reg <= '0;
            valid_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    tvfc_pkg::REG_FOLLOW_SPEED: follow_speed_reg <= cfg_data;
                    tvfc_pkg::REG_FRAME_INTERVAL: frame_interval_reg <= cfg_data;
                    tvfc_pkg::REG_FRAMES_ACROSS: frames_across_reg <= cfg_data[7:0];
                    tvfc_pkg::REG_FRAMES_DOWN: frames_down_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (accept) cnt_reg <= '0;
            if (state_reg == S_INIT || (emit_fire && cnt_reg != LAST_IDX)) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == S_READ) coord_reg <= '0;
            if (state_reg == S_ISSUE) coord_reg <= coord_reg + 3'd1;
            if (state_reg == S_FRAME) begin
                frame_clock_reg <= clock_next;
                frame_column_reg <= column_next;
                frame_line_reg <= line_next;
            end
            if (wr_en) valid_reg[cnt_reg] <= 1'b1;
            // hold the result until taken
            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pair_reg <= anchors;
            dt_reg <= s_tdata[tvfc_pkg::DT_W-1:0];
            alpha_reg <= alpha_next;
        end else if (res_tag.valid) begin
            pair_reg[res_tag.idx] <= res_value;
        end
        if (wr_en) mem[cnt_reg] <= pair_reg;
        rd_data_reg <= mem[cnt_reg];
        rd_valid_reg <= valid_reg[cnt_reg];
        if (emit_fire) begin
            prev_reg <= pair_reg;
            m_tdata_reg <= {2'b00, frame_line_reg, frame_column_reg, pair_reg,
                            tvfc_pkg::SEG_W'(cnt_reg)};
            m_tlast_reg <= (cnt_reg == LAST_IDX);
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule
